/* rtl/core/trcp_pkg.sv */
// Shared types and constants for the telnet receive command parser.
// Holds beat structs, parse modes, event codes and telnet byte codes.
// No dependencies.
package trcp_pkg;

  // Telnet byte codes
  localparam logic [7:0] TEL_SE   = 8'd240;
  localparam logic [7:0] TEL_NOP  = 8'd241;
  localparam logic [7:0] TEL_BRK  = 8'd243;
  localparam logic [7:0] TEL_GA   = 8'd249;
  localparam logic [7:0] TEL_SB   = 8'd250;
  localparam logic [7:0] TEL_WILL = 8'd251;
  localparam logic [7:0] TEL_DONT = 8'd254;
  localparam logic [7:0] TEL_IAC  = 8'd255;

  // Event codes
  localparam logic [3:0] EV_NONE   = 4'd0;
  localparam logic [3:0] EV_FILTER = 4'd1;
  localparam logic [3:0] EV_NOP    = 4'd2;
  localparam logic [3:0] EV_NEG    = 4'd10;

  // Operation codes
  localparam logic OP_LINK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam logic CFG_FILTER = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  localparam int unsigned LIMIT_W = 7;

  typedef enum logic [4:0] {
    MODE_DATA    = 5'b00001,
    MODE_CMD     = 5'b00010,
    MODE_OPTION  = 5'b00100,
    MODE_SUB     = 5'b01000,
    MODE_SUB_IAC = 5'b10000
  } mode_e;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] neg_command;
    logic [7:0] neg_option;
    logic       read_valid;
    logic [7:0] read_data;
    logic [6:0] fill_count;
    logic       dropped;
    logic       nvt_seen;
  } out_item_t;

  // Parser to FIFO control and result path
  typedef struct packed {
    logic       push;
    logic [7:0] push_data;
    logic [3:0] event_res;
    logic [7:0] neg_command;
    logic [7:0] neg_option;
    logic       nvt_seen;
  } parse_res_t;

  // FIFO control status for one beat
  typedef struct packed {
    logic       rd_valid;
    logic       dropped;
    logic [6:0] fill_count;
  } fifo_res_t;

endpackage

/* rtl/core/telnet_rx_command_parser_top.sv */
// Top level of the telnet receive command parser.
// Depends on trcp_pkg, trcp_parser and trcp_fifo_ctrl.
//
// Takes one beat per clock: a link byte (op 0) or a host read (op 1), and
// returns one result beat for each. Back-to-back beats are accepted at a
// sustained rate of one per cycle while the output is taken. On acceptance the
// beat's control result is registered in stage 1 while the registered read
// of the receive store RAM lands, and both move on into the output register
// once it frees up. The output register parts the two sides, so one more
// input beat is taken while a finished result waits; after that the input
// stalls until the output is taken.
// Link bytes run through the IAC state machine: commands raise events,
// WILL/WONT/DO/DONT carry their option byte into a negotiation event,
// subnegotiation is skipped up to IAC SE, IAC IAC stores 255, and plain
// bytes enter the FIFO, which drops and flags bytes when full. Writing
// buffer_limit with a new value empties the FIFO; write configuration
// only while no beat is in flight. There is no clearing pass after reset.
module telnet_rx_command_parser_top #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  trcp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output trcp_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import trcp_pkg::*;

  logic [7:0]         filter_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               clear;

  logic       accept, s1_move;
  logic       s1_v_q, out_v_q;
  out_item_t  s1_q, s1_d, out_q, out_d;
  parse_res_t pres;
  fifo_res_t  fres;
  logic [7:0] rd_data;

  // Configuration registers; a changed limit empties the FIFO
  assign clear = cfg_we_i && (cfg_idx_i == CFG_LIMIT) &&
                 (cfg_data_i[LIMIT_W-1:0] != limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= 8'd0;
      limit_q  <= LIMIT_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER: filter_q <= cfg_data_i;
        CFG_LIMIT:  limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default:    filter_q <= filter_q;
      endcase
    end
  end

  // Handshake: advance stage 1 when the output register frees up
  assign s1_move    = !out_v_q || out_ready_i;
  assign in_ready_o = !s1_v_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  trcp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept && (in_data_i.op == OP_LINK)),
    .byte_i       (in_data_i.in_byte),
    .filter_char_i(filter_q),
    .res_o        (pres)
  );

  trcp_fifo_ctrl #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (pres.push),
    .push_data_i(pres.push_data),
    .pop_i      (accept && (in_data_i.op == OP_READ)),
    .clear_i    (clear),
    .limit_i    (limit_q),
    .res_o      (fres),
    .rd_data_o  (rd_data)
  );

  always_comb begin
    s1_d             = '0;
    s1_d.event_res   = pres.event_res;
    s1_d.neg_command = pres.neg_command;
    s1_d.neg_option  = pres.neg_option;
    s1_d.read_valid  = fres.rd_valid;
    s1_d.fill_count  = fres.fill_count;
    s1_d.dropped     = fres.dropped;
    s1_d.nvt_seen    = pres.nvt_seen;
  end

  // Stage 1: hold control result while the RAM read lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // Output register: merge popped byte; zero when nothing was read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_move) begin
      out_v_q <= s1_v_q;
    end
  end

  always_comb begin
    out_d           = s1_q;
    out_d.read_data = s1_q.read_valid ? rd_data : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // A stalled stage 1 keeps its beat
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_move) |=> (s1_v_q && $stable(s1_q)))
    else $error("stage 1 beat lost under stall");

  // A read beat carries no event and no drop
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.read_valid) |->
      (out_q.event_res == EV_NONE && !out_q.dropped))
    else $error("read beat carries parser result");

  // A dropped byte means the FIFO was holding entries
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.dropped) |-> (out_q.fill_count != 7'd0))
    else $error("drop flagged with empty FIFO");

  // Negotiation events always carry the sticky flag
  a_neg_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.event_res == EV_NEG) |-> out_q.nvt_seen)
    else $error("negotiation event without sticky flag");

endmodule

/* rtl/core/trcp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module trcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/trcp_parser.sv */
// IAC mode state machine: classifies each link byte per beat.
// Depends on trcp_pkg.
module trcp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          filter_char_i,
  output trcp_pkg::parse_res_t res_o
);
  import trcp_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] pend_q, pend_d;
  logic       nvt_q, nvt_d;
  parse_res_t res;

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    nvt_d  = nvt_q;
    res    = '0;
    unique case (mode_q)
      MODE_DATA: begin
        if ((filter_char_i != 8'd0) && (byte_i == filter_char_i)) begin
          res.event_res = EV_FILTER;
        end else if (byte_i == TEL_IAC) begin
          mode_d = MODE_CMD;
        end else begin
          res.push      = 1'b1;
          res.push_data = byte_i;
        end
      end
      MODE_CMD: begin
        mode_d = MODE_DATA;
        if (byte_i == TEL_NOP) begin
          res.event_res = EV_NOP;
        end else if ((byte_i >= TEL_BRK) && (byte_i <= TEL_GA)) begin
          // break through go-ahead map onto the low nibble
          res.event_res = byte_i[3:0];
        end else if (byte_i == TEL_SB) begin
          mode_d = MODE_SUB;
        end else if ((byte_i >= TEL_WILL) && (byte_i <= TEL_DONT)) begin
          pend_d = byte_i;
          nvt_d  = 1'b1;
          mode_d = MODE_OPTION;
        end else if (byte_i == TEL_IAC) begin
          res.push      = 1'b1;
          res.push_data = TEL_IAC;
        end
      end
      MODE_OPTION: begin
        res.event_res   = EV_NEG;
        res.neg_command = pend_q;
        res.neg_option  = byte_i;
        mode_d          = MODE_DATA;
      end
      MODE_SUB: begin
        if (byte_i == TEL_IAC) begin
          mode_d = MODE_SUB_IAC;
        end
      end
      MODE_SUB_IAC: begin
        mode_d = (byte_i == TEL_SE) ? MODE_DATA : MODE_SUB;
      end
      default: begin
        mode_d = MODE_DATA;
      end
    endcase
    res.nvt_seen = nvt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DATA;
      pend_q <= 8'd0;
      nvt_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      nvt_q  <= nvt_d;
    end
  end

  assign res_o = step_i ? res : parse_res_t'{nvt_seen: nvt_q, default: '0};

endmodule

/* rtl/core/trcp_fifo_ctrl.sv */
// Receive FIFO: pointers, count and live size around one store RAM.
// Depends on trcp_pkg and trcp_ram.
module trcp_fifo_ctrl #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic [7:0]                        push_data_i,
  input  logic                              pop_i,
  input  logic                              clear_i,
  input  logic [trcp_pkg::LIMIT_W-1:0]      limit_i,
  output trcp_pkg::fifo_res_t               res_o,
  output logic [7:0]                        rd_data_o
);
  import trcp_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [AW-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] size, cnt_x, rnext, wnext, cnt_dx;
  logic          full, empty, wr_en, rd_en;

  // Clamp the limit into one through the built depth
  always_comb begin
    if (limit_i == '0) begin
      size = SW'(1);
    end else if (SW'(limit_i) > SW'(FIFO_DEPTH)) begin
      size = SW'(FIFO_DEPTH);
    end else begin
      size = SW'(limit_i);
    end
  end

  assign cnt_x = SW'(cnt_q);
  assign full  = (cnt_x >= size);
  assign empty = (cnt_q == '0);
  assign wr_en = push_i && !full;
  assign rd_en = pop_i && !empty;
  assign wnext = SW'(wptr_q) + SW'(1);
  assign rnext = SW'(rptr_q) + SW'(1);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (clear_i) begin
      wptr_d = '0;
      rptr_d = '0;
      cnt_d  = '0;
    end else if (wr_en) begin
      wptr_d = (wnext >= size) ? '0 : wnext[AW-1:0];
      cnt_d  = cnt_q + CW'(1);
    end else if (rd_en) begin
      rptr_d = (rnext >= size) ? '0 : rnext[AW-1:0];
      cnt_d  = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  assign cnt_dx         = SW'(cnt_d);
  assign res_o.rd_valid   = rd_en;
  assign res_o.dropped    = push_i && full;
  assign res_o.fill_count = cnt_dx[6:0];

  // Push and pop never share a beat, and a popped entry was written at an
  // earlier edge, so the store needs no forwarding.
  trcp_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wptr_q),
    .wdata_i(push_data_i),
    .re_i   (rd_en),
    .raddr_i(rptr_q),
    .rdata_o(rd_data_o)
  );

endmodule
